@@ rtl/fpr_pkg.sv @@
`default_nettype none

package fpr_pkg;

    localparam int CFG_W     = 5;
    localparam int PAGE_IN_W = 16;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
    localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic scan;
        logic commit_hit;
        logic commit_miss;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/fpr_ctrl.sv @@
`default_nettype none

module fpr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire fpr_pkg::t_status    i_status,
    output fpr_pkg::t_cmd            o_cmd
);

    fpr_pkg::t_state r_state;
    fpr_pkg::t_state n_state;
    logic            w_decided;

    assign o_in_stall = (r_state != fpr_pkg::S_IDLE);
    assign w_decided  = i_status.match || i_status.done;

    always_comb begin
        n_state           = r_state;
        o_cmd.load_in     = 1'b0;
        o_cmd.scan        = 1'b0;
        o_cmd.commit_hit  = 1'b0;
        o_cmd.commit_miss = 1'b0;
        unique case (r_state)
            fpr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = fpr_pkg::S_SCAN;
                end
            end
            fpr_pkg::S_SCAN: begin
                // hold the decision until the output register frees up
                o_cmd.scan = !w_decided;
                if (w_decided && i_status.out_free) begin
                    o_cmd.commit_hit  = i_status.match;
                    o_cmd.commit_miss = !i_status.match;
                    n_state           = fpr_pkg::S_IDLE;
                end
            end
            default: n_state = fpr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fpr_datapath.sv @@
`default_nettype none

module fpr_datapath #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fpr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic [fpr_pkg::PAGE_IN_W-1:0] i_page_number,
    input  wire fpr_pkg::t_cmd                 i_cmd,
    output fpr_pkg::t_status                   o_status,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_hit,
    output logic [fpr_pkg::SLOT_W-1:0]         o_frame_slot,
    output logic [fpr_pkg::CNT_W-1:0]          o_hit_total,
    output logic [fpr_pkg::CNT_W-1:0]          o_fault_total
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    logic [fpr_pkg::CFG_W-1:0]  r_frames;
    logic [PAGE_BITS-1:0]       r_mem [FRAMES];
    logic [FRAMES-1:0]          r_valid;
    logic [PAGE_BITS-1:0]       r_page;
    logic [CW-1:0]              r_idx;
    logic [PAGE_BITS-1:0]       r_rd_data;
    logic                       r_rd_vbit;
    logic                       r_chk_vld;
    logic [IW-1:0]              r_chk_idx;
    logic [IW-1:0]              r_victim;
    logic [fpr_pkg::CNT_W-1:0]  r_hits;
    logic [fpr_pkg::CNT_W-1:0]  r_faults;

    logic [CW-1:0]              w_n;
    logic                       w_rd_en;
    logic [IW-1:0]              w_slot;
    logic [CW-1:0]              w_slot_inc;
    logic [IW-1:0]              w_victim_nxt;
    logic [fpr_pkg::CNT_W-1:0]  w_hits_inc;
    logic [fpr_pkg::CNT_W-1:0]  w_faults_inc;

    // clamp the frame count into 1..FRAMES
    always_comb begin
        priority if (r_frames == '0) begin
            w_n = CW'(1);
        end else if (32'(r_frames) > FRAMES) begin
            w_n = CW'(FRAMES);
        end else begin
            w_n = CW'(r_frames);
        end
    end

    assign w_rd_en = i_cmd.scan && (r_idx < w_n);

    assign o_status.match    = r_chk_vld && r_rd_vbit && (r_rd_data == r_page);
    assign o_status.done     = !r_chk_vld && (r_idx >= w_n);
    assign o_status.out_free = !o_out_valid || !i_out_stall;

    // a stale pointer past the count loads frame 0
    assign w_slot       = (CW'(r_victim) < w_n) ? r_victim : '0;
    assign w_slot_inc   = CW'(w_slot) + CW'(1);
    assign w_victim_nxt = (w_slot_inc < w_n) ? IW'(w_slot_inc) : '0;
    assign w_hits_inc   = (r_hits == fpr_pkg::CNT_MAX) ? r_hits : r_hits + 1'b1;
    assign w_faults_inc = (r_faults == fpr_pkg::CNT_MAX) ? r_faults : r_faults + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[IW-1:0]];
        end
        if (i_cmd.commit_miss) begin
            r_mem[w_slot] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_page <= PAGE_BITS'(i_page_number);
        end
        if (w_rd_en) begin
            r_chk_idx <= r_idx[IW-1:0];
        end
        if (i_cmd.commit_hit) begin
            o_hit         <= 1'b1;
            o_frame_slot  <= fpr_pkg::SLOT_W'(r_chk_idx);
            o_hit_total   <= w_hits_inc;
            o_fault_total <= r_faults;
        end else if (i_cmd.commit_miss) begin
            o_hit         <= 1'b0;
            o_frame_slot  <= fpr_pkg::SLOT_W'(w_slot);
            o_hit_total   <= r_hits;
            o_fault_total <= w_faults_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= fpr_pkg::CFG_RESET;
            r_valid     <= '0;
            r_idx       <= '0;
            r_rd_vbit   <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_victim    <= '0;
            r_hits      <= '0;
            r_faults    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames <= i_cfg_wdata;
            end
            if (i_cmd.load_in) begin
                r_idx     <= '0;
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_chk_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_rd_vbit <= r_valid[r_idx[IW-1:0]];
                    r_idx     <= r_idx + 1'b1;
                end
            end
            if (i_cmd.commit_hit) begin
                r_hits <= w_hits_inc;
            end
            if (i_cmd.commit_miss) begin
                r_valid[w_slot] <= 1'b1;
                r_victim        <= w_victim_nxt;
                r_faults        <= w_faults_inc;
            end
            if (i_cmd.commit_hit || i_cmd.commit_miss) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/fifo_page_replacement.sv @@
// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_stall   i_page_number
// result   out        o_out_valid / i_out_stall o_hit, o_frame_slot, o_hit_total, o_fault_total
// config   in         i_cfg_we                  i_cfg_wdata (frames in use)
//
// One reference at a time; the frame store is read one entry per cycle.
// A hit is decided as soon as its frame's entry is checked, a miss once all frames
// in use (16 at reset) have been checked.
// Reset clears all frame valid bits, the replacement pointer and both totals.
// A stalled result holds the block in the scan state until it is taken.
`default_nettype none

module fifo_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fpr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [fpr_pkg::PAGE_IN_W-1:0] i_page_number,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_hit,
    output logic [fpr_pkg::SLOT_W-1:0]         o_frame_slot,
    output logic [fpr_pkg::CNT_W-1:0]          o_hit_total,
    output logic [fpr_pkg::CNT_W-1:0]          o_fault_total
);

    fpr_pkg::t_cmd    w_cmd;
    fpr_pkg::t_status w_status;

    fpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fpr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_page_number (i_page_number),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_frame_slot  (o_frame_slot),
        .o_hit_total   (o_hit_total),
        .o_fault_total (o_fault_total)
    );

endmodule

`default_nettype wire

@@ tb/page_ref_checker.sv @@
`default_nettype none

module page_ref_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fpr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic [fpr_pkg::PAGE_IN_W-1:0] i_page_number,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic                          i_hit,
    input  wire logic [fpr_pkg::SLOT_W-1:0]    i_frame_slot,
    input  wire logic [fpr_pkg::CNT_W-1:0]     i_hit_total,
    input  wire logic [fpr_pkg::CNT_W-1:0]     i_fault_total,
    output int                                 o_mismatch_count,
    output int                                 o_outstanding
);

    localparam int FRAME_COUNT = 16;

    typedef struct packed {
        logic                       hit;
        logic [fpr_pkg::SLOT_W-1:0] slot;
        logic [fpr_pkg::CNT_W-1:0]  hit_total;
        logic [fpr_pkg::CNT_W-1:0]  fault_total;
    } t_lookup;

    logic [fpr_pkg::PAGE_IN_W-1:0] frame_page [FRAME_COUNT];
    logic [FRAME_COUNT-1:0]        frame_loaded;
    int unsigned                   victim;
    logic [fpr_pkg::CNT_W-1:0]     hit_tally;
    logic [fpr_pkg::CNT_W-1:0]     fault_tally;
    logic [fpr_pkg::CFG_W-1:0]     frames_cfg;
    t_lookup                       awaited_lookups [$];
    int                            mismatch_total;

    initial begin
        frame_loaded     = '0;
        victim           = 0;
        hit_tally        = '0;
        fault_tally      = '0;
        frames_cfg       = fpr_pkg::CFG_RESET;
        mismatch_total   = 0;
        o_mismatch_count = 0;
        o_outstanding    = 0;
    end

    // Search the frames in use, then load on a fault and advance the FIFO pointer.
    function automatic t_lookup resolve_reference(
        input logic [fpr_pkg::PAGE_IN_W-1:0] page
    );
        t_lookup     r;
        int unsigned n;
        int unsigned slot;
        bit          found;
        n = frames_cfg;
        if (n < 1) n = 1;
        if (n > FRAME_COUNT) n = FRAME_COUNT;
        found = 1'b0;
        slot  = 0;
        for (int i = 0; i < n; i++) begin
            if (!found && frame_loaded[i] && frame_page[i] == page) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            if (hit_tally != fpr_pkg::CNT_MAX) hit_tally = hit_tally + 1'b1;
        end else begin
            // a pointer stranded past a lowered count restarts at frame 0
            slot = (victim < n) ? victim : 0;
            frame_page[slot]   = page;
            frame_loaded[slot] = 1'b1;
            victim = (slot + 1 < n) ? slot + 1 : 0;
            if (fault_tally != fpr_pkg::CNT_MAX) fault_tally = fault_tally + 1'b1;
        end
        r.hit         = found;
        r.slot        = fpr_pkg::SLOT_W'(slot);
        r.hit_total   = hit_tally;
        r.fault_total = fault_tally;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [fpr_pkg::CNT_W-1:0] want,
                               input logic [fpr_pkg::CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            frame_loaded = '0;
            victim       = 0;
            hit_tally    = '0;
            fault_tally  = '0;
            frames_cfg   = fpr_pkg::CFG_RESET;
            awaited_lookups.delete();
        end else begin
            if (i_cfg_we) frames_cfg = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (awaited_lookups.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, %s",
                             $time, $sformatf("actual hit=%0d slot=%0d",
                                              i_hit, i_frame_slot));
                    mismatch_total++;
                end else begin
                    want = awaited_lookups.pop_front();
                    check_field("hit", fpr_pkg::CNT_W'(want.hit), fpr_pkg::CNT_W'(i_hit));
                    check_field("frame_slot", fpr_pkg::CNT_W'(want.slot),
                                fpr_pkg::CNT_W'(i_frame_slot));
                    check_field("hit_total", want.hit_total, i_hit_total);
                    check_field("fault_total", want.fault_total, i_fault_total);
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_lookups.push_back(resolve_reference(i_page_number));
        end
        o_outstanding    <= awaited_lookups.size();
        o_mismatch_count <= mismatch_total;
    end

endmodule

`default_nettype wire

@@ tb/fifo_page_replacement_tb.sv @@
`default_nettype none

module fifo_page_replacement_tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 60;
    localparam int LONG_HOLD     = 250;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [fpr_pkg::CFG_W-1:0]     i_cfg_wdata;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [fpr_pkg::PAGE_IN_W-1:0] i_page_number;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_hit;
    logic [fpr_pkg::SLOT_W-1:0]    o_frame_slot;
    logic [fpr_pkg::CNT_W-1:0]     o_hit_total;
    logic [fpr_pkg::CNT_W-1:0]     o_fault_total;

    int          mismatch_count;
    int          outstanding;
    int unsigned cycle_count;
    bit          send_fast;
    bit          take_fast;
    bit          long_hold_pending;

    fifo_page_replacement DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_page_number (i_page_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_frame_slot  (o_frame_slot),
        .o_hit_total   (o_hit_total),
        .o_fault_total (o_fault_total)
    );

    page_ref_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_page_number    (i_page_number),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_hit            (o_hit),
        .i_frame_slot     (o_frame_slot),
        .i_hit_total      (o_hit_total),
        .i_fault_total    (o_fault_total),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stall before each transfer unless take_fast, one long hold-off on request.
    initial begin : result_sink
        int unsigned hold_n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_pending) begin
                hold_n            = LONG_HOLD;
                long_hold_pending = 1'b0;
            end else begin
                hold_n = take_fast ? 0 : $urandom_range(0, 9);
            end
            @(negedge i_clk);
            i_out_stall = (hold_n != 0);
            repeat (hold_n) @(negedge i_clk);
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_page(input logic [fpr_pkg::PAGE_IN_W-1:0] page);
        int unsigned gap;
        gap = send_fast ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_page_number = page;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drain all references before touching the frame count.
    task automatic set_frames(input logic [fpr_pkg::CFG_W-1:0] count);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = count;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin : stimulus
        logic [fpr_pkg::CFG_W-1:0]     plan [PHASES];
        logic [fpr_pkg::PAGE_IN_W-1:0] pool [$];
        int unsigned                   n_eff;
        int unsigned                   pool_n;
        int unsigned                   mode;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        i_in_valid        = 1'b0;
        i_page_number     = '0;
        send_fast         = 1'b0;
        take_fast         = 1'b0;
        long_hold_pending = 1'b0;
        plan = '{5'd16, 5'd1, 5'd17, 5'd4, 5'd31, 5'd8, 5'd2, 5'd0,
                 5'd15, 5'd3, 5'd12, 5'd16};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extremes and the first loads at the reset frame count.
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        // Pointer now sits past a lowered count; 16'hAAAA stays in an unsearched frame.
        set_frames(5'd3);
        send_page(16'h1234);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        // Zero behaves as one frame.
        set_frames(5'd0);
        send_page(16'h1234);
        send_page(16'h0001);
        send_page(16'h0002);
        // Counts above the frame store clamp; 16'hAAAA now sits in two frames.
        set_frames(5'd31);
        send_page(16'hAAAA);
        send_page(16'h5555);
        send_page(16'h0002);

        for (int p = 0; p < PHASES; p++) begin
            if (p >= 9) plan[p] = fpr_pkg::CFG_W'($urandom_range(0, 31));
            set_frames(plan[p]);
            n_eff = (plan[p] == 0) ? 1 : (plan[p] > 16 ? 16 : plan[p]);
            mode      = $urandom_range(0, 3);
            send_fast = mode[0];
            take_fast = mode[1];
            if (p == 2) begin
                send_fast         = 1'b1;
                take_fast         = 1'b0;
                long_hold_pending = 1'b1;
            end
            // Keep a working set near the frame count so hits and evictions both occur.
            pool.delete();
            pool_n = n_eff + $urandom_range(0, 4);
            repeat (pool_n) pool.push_back(fpr_pkg::PAGE_IN_W'($urandom_range(0, 65535)));
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85)
                    send_page(pool[$urandom_range(0, pool_n - 1)]);
                else
                    send_page(fpr_pkg::PAGE_IN_W'($urandom_range(0, 65535)));
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
